// ===== rtl/plfk_pkg.sv =====
// Shared types, constants and helpers of the plasma lens field kick block.
// No dependencies; every other file but rtl/plfk_checker.sv imports this package.
`default_nettype none
package plfk_pkg;

    localparam logic FUNC_LOAD     = 1'b0;
    localparam logic FUNC_PARTICLE = 1'b1;

    localparam logic [1:0] CFG_RADIAL_SCALE = 2'd0;
    localparam logic [1:0] CFG_FIELD_SCALE  = 2'd1;
    localparam logic [1:0] CFG_NODE_COUNT   = 2'd2;

    localparam logic [31:0] RADIAL_SCALE_RESET = 32'h0100_0000;
    localparam logic [24:0] XI_MAX  = 25'h100_0000;
    localparam logic [24:0] ONE_Q16 = 25'h001_0000;
    localparam logic signed [49:0] ACC_LIM = 50'sd274877906944;

    // Horner coefficients in Q.32: the top one starts the accumulator,
    // the rest are added in the order c4 down to c0.
    localparam logic signed [31:0] COEF_TOP = -32'sd461339004;
    localparam logic signed [31:0] HORNER_COEF [5] = '{
        32'sd946417519, -32'sd754483161, 32'sd84476316,
        -32'sd33496020, 32'sd677531091
    };

    typedef struct packed {
        logic        is_load;
        logic [3:0]  node_index;
        logic [31:0] node_pos;
        logic [23:0] node_density;
        logic [15:0] cell_position;
        logic [31:0] px;
        logic [31:0] py;
    } item_t;

    typedef struct packed {
        logic [31:0] radial_scale;
        logic [31:0] field_scale;
        logic [4:0]  node_count;
    } cfg_t;

    // Applies the sign to a magnitude and saturates to 32 signed bits.
    function automatic logic [31:0] sat_out(input logic [63:0] mag, input logic neg);
        logic [63:0] lim;
        begin
            if (neg) begin
                lim = (mag > 64'h8000_0000) ? 64'h8000_0000 : mag;
                sat_out = 32'(64'd0 - lim);
            end else begin
                sat_out = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
            end
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/plfk_front.sv =====
// Front end: input handshake, item classification and a two-entry queue.
// Depends on plfk_pkg for the item type and function codes.
`default_nettype none
module plfk_front import plfk_pkg::*; #(
    parameter int MAX_NODES = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic [3:0]  s_node_index,
    input  wire logic [31:0] s_node_pos,
    input  wire logic [23:0] s_node_density,
    input  wire logic [15:0] s_cell_position,
    input  wire logic [31:0] s_px,
    input  wire logic [31:0] s_py,
    output logic             q_valid,
    output item_t            q_item,
    input  wire logic        q_pop
);

    item_t      queue_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;
    item_t      item_in;

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = queue_reg[rd_ptr_reg];
    assign pop     = q_pop && q_valid;

    // A load aimed beyond the table is dropped here and never queued.
    assign push = s_valid && s_ready &&
                  (s_func == FUNC_PARTICLE || 32'(s_node_index) < MAX_NODES);

    always_comb begin
        item_in.is_load       = (s_func == FUNC_LOAD);
        item_in.node_index    = s_node_index;
        item_in.node_pos      = s_node_pos;
        item_in.node_density  = s_node_density;
        item_in.cell_position = s_cell_position;
        item_in.px            = s_px;
        item_in.py            = s_py;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)      count_reg <= count_reg + 2'd1;
            else if (pop && !push) count_reg <= count_reg - 2'd1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/plfk_back.sv =====
// Back end: sequencer around one shared 32x32 multiplier, a bit-serial square
// root, a bit-serial divider, the profile table and the result register.
// Depends on plfk_pkg.
`default_nettype none
module plfk_back import plfk_pkg::*; #(
    parameter int MAX_NODES = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cfg_t        cfg,
    input  wire logic        q_valid,
    input  wire item_t       q_item,
    output logic             q_pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_bx_change,
    output logic [31:0]      m_by_change
);

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NW = $clog2(MAX_NODES + 1);

    localparam logic [4:0] S_IDLE = 5'd0,  S_SQX = 5'd1,  S_SQY = 5'd2,  S_SQS = 5'd3,
                           S_SQRT = 5'd4,  S_XI = 5'd5,   S_XIC = 5'd6,  S_HLO = 5'd7,
                           S_HHI = 5'd8,   S_HADD = 5'd9, S_FS = 5'd10,  S_FSR = 5'd11,
                           S_DRD = 5'd12,  S_DCHK = 5'd13, S_DMUL = 5'd14, S_DDIVS = 5'd15,
                           S_DIV = 5'd16,  S_DNE = 5'd17, S_NE1 = 5'd18, S_NE2 = 5'd19,
                           S_NE3 = 5'd20,  S_SINR = 5'd21, S_COSR = 5'd22, S_BXL = 5'd23,
                           S_BXH = 5'd24,  S_BXS = 5'd25, S_BYL = 5'd26, S_BYH = 5'd27,
                           S_BYS = 5'd28,  S_OUT = 5'd29;

    logic [4:0]  state_reg;
    logic [5:0]  cnt_reg;
    logic [2:0]  hstep_reg;

    logic [31:0] pos_mem [MAX_NODES];
    logic [23:0] den_mem [MAX_NODES];
    logic [31:0] pos_rd_reg;
    logic [23:0] den_rd_reg;

    logic [31:0] x_reg, y_reg;
    logic [15:0] cell_reg;
    logic [63:0] prod_reg, lo_reg, sum_reg;
    logic [33:0] sq_rem_reg;
    logic [31:0] root_reg;
    logic [24:0] xi_reg;
    logic signed [39:0] acc_reg;
    logic [38:0] m1_reg;
    logic [47:0] m_reg;
    logic [24:0] ne_reg;
    logic [NW-1:0] j_reg;
    logic [31:0] prev_pos_reg, x0_reg, x1_reg;
    logic [23:0] prev_den_reg, d0_reg, dd_mag_reg;
    logic        dd_neg_reg;
    logic [63:0] div_num_reg;
    logic [32:0] div_rem_reg;
    logic [31:0] div_den_reg;
    logic [4:0]  div_ret_reg;
    logic [30:0] sn_reg, cs_reg;
    logic [31:0] bx_res_reg, by_res_reg;
    logic        m_valid_reg;
    logic [31:0] bx_out_reg, by_out_reg;

    logic [31:0] mul_a, mul_b;
    logic [31:0] ax, ay, fs_mag, cell_p;
    logic [38:0] acc_mag;
    logic [33:0] sq_sh, sq_trial, sq_rem_next;
    logic [31:0] root_next;
    logic [63:0] wide_sum;
    logic signed [49:0] hterm, hsum;
    logic signed [39:0] acc_next;
    logic [32:0] div_sh;
    logic        div_ge;
    logic [NW-1:0] n_eff;
    logic [39:0] xi_raw;
    logic [63:0] out_mag;
    logic        neg_b;
    logic signed [24:0] dd_full;

    assign m_valid     = m_valid_reg;
    assign m_bx_change = bx_out_reg;
    assign m_by_change = by_out_reg;
    assign q_pop       = (state_reg == S_IDLE);

    assign ax      = x_reg[31] ? 32'(-x_reg) : x_reg;
    assign ay      = y_reg[31] ? 32'(-y_reg) : y_reg;
    assign fs_mag  = cfg.field_scale[31] ? 32'(-cfg.field_scale) : cfg.field_scale;
    assign acc_mag = acc_reg[39] ? 39'(-acc_reg) : acc_reg[38:0];
    assign cell_p  = {cell_reg, 16'd0};
    assign neg_b   = acc_reg[39] ^ cfg.field_scale[31];
    assign xi_raw  = prod_reg[63:24];
    assign dd_full = $signed({1'b0, den_rd_reg}) - $signed({1'b0, prev_den_reg});

    always_comb begin
        if (32'(cfg.node_count) > MAX_NODES) n_eff = NW'(MAX_NODES);
        else n_eff = NW'(cfg.node_count);
    end

    // Square root: one result bit per cycle from the top pair of radicand bits.
    always_comb begin
        sq_sh    = {sq_rem_reg[31:0], sum_reg[63:62]};
        sq_trial = {root_reg, 2'b01};
        if (sq_sh >= sq_trial) begin
            sq_rem_next = sq_sh - sq_trial;
            root_next   = {root_reg[30:0], 1'b1};
        end else begin
            sq_rem_next = sq_sh;
            root_next   = {root_reg[30:0], 1'b0};
        end
    end

    // Restoring division: one quotient bit per cycle shifted into div_num_reg.
    always_comb begin
        div_sh = {div_rem_reg[31:0], div_num_reg[63]};
        div_ge = (div_sh >= {1'b0, div_den_reg});
    end

    // The wide products are built from a low and a high partial product.
    assign wide_sum = {prod_reg[31:0], 32'd0} + lo_reg;

    always_comb begin
        hterm = acc_reg[39] ? -$signed({2'b00, wide_sum[63:16]})
                            : $signed({2'b00, wide_sum[63:16]});
        if (hstep_reg < 3'd5) hsum = hterm + 50'(HORNER_COEF[hstep_reg]);
        else hsum = hterm;
        if (hsum > ACC_LIM) acc_next = 40'(ACC_LIM);
        else if (hsum < -ACC_LIM) acc_next = 40'(-ACC_LIM);
        else acc_next = 40'(hsum);
    end

    assign out_mag = {prod_reg[61:0], 2'b00} + {30'd0, lo_reg[63:30]};

    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (state_reg)
            S_SQX:  begin mul_a = ax; mul_b = ax; end
            S_SQY:  begin mul_a = ay; mul_b = ay; end
            S_XI:   begin mul_a = root_reg; mul_b = cfg.radial_scale; end
            S_HLO:  begin mul_a = acc_mag[31:0]; mul_b = {7'd0, xi_reg}; end
            S_HHI:  begin mul_a = {25'd0, acc_mag[38:32]}; mul_b = {7'd0, xi_reg}; end
            S_FS:   begin mul_a = {9'd0, acc_mag[38:16]}; mul_b = fs_mag; end
            S_DMUL: begin mul_a = {8'd0, dd_mag_reg}; mul_b = cell_p - x0_reg; end
            S_NE1:  begin mul_a = m1_reg[31:0]; mul_b = {7'd0, ne_reg}; end
            S_NE2:  begin mul_a = {25'd0, m1_reg[38:32]}; mul_b = {7'd0, ne_reg}; end
            S_BXL:  begin mul_a = m_reg[31:0]; mul_b = {1'b0, sn_reg}; end
            S_BXH:  begin mul_a = {16'd0, m_reg[47:32]}; mul_b = {1'b0, sn_reg}; end
            S_BYL:  begin mul_a = m_reg[31:0]; mul_b = {1'b0, cs_reg}; end
            S_BYH:  begin mul_a = {16'd0, m_reg[47:32]}; mul_b = {1'b0, cs_reg}; end
            default: begin mul_a = 32'd0; mul_b = 32'd0; end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    // Profile table: written by load items, read by the node scan through a registered read port.
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && q_valid && q_item.is_load) begin
            pos_mem[AW'(q_item.node_index)] <= q_item.node_pos;
            den_mem[AW'(q_item.node_index)] <= q_item.node_density;
        end
        pos_rd_reg <= pos_mem[j_reg[AW-1:0]];
        den_rd_reg <= den_mem[j_reg[AW-1:0]];
    end

    // Datapath registers of the sequencer.
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                x_reg    <= q_item.px;
                y_reg    <= q_item.py;
                cell_reg <= q_item.cell_position;
            end
            S_SQY: sum_reg <= prod_reg;
            S_SQS: begin
                sum_reg    <= sum_reg + prod_reg;
                sq_rem_reg <= 34'd0;
                root_reg   <= 32'd0;
            end
            S_SQRT: begin
                sq_rem_reg <= sq_rem_next;
                root_reg   <= root_next;
                sum_reg    <= {sum_reg[61:0], 2'b00};
                if (cnt_reg == 6'd0 && root_next == 32'd0) begin
                    bx_res_reg <= 32'd0;
                    by_res_reg <= 32'd0;
                end
            end
            S_XIC: begin
                xi_reg    <= (xi_raw > 40'(XI_MAX)) ? XI_MAX : xi_raw[24:0];
                acc_reg   <= 40'(COEF_TOP);
                hstep_reg <= 3'd0;
            end
            S_HHI: lo_reg <= prod_reg;
            S_HADD: begin
                acc_reg   <= acc_next;
                hstep_reg <= hstep_reg + 3'd1;
            end
            S_FSR: begin
                m1_reg <= prod_reg[54:16];
                j_reg  <= '0;
                ne_reg <= ONE_Q16;
            end
            S_DCHK: begin
                x0_reg       <= prev_pos_reg;
                x1_reg       <= pos_rd_reg;
                d0_reg       <= prev_den_reg;
                dd_neg_reg   <= dd_full[24];
                dd_mag_reg   <= dd_full[24] ? 24'(-dd_full) : dd_full[23:0];
                prev_pos_reg <= pos_rd_reg;
                prev_den_reg <= den_rd_reg;
                j_reg        <= j_reg + NW'(1);
            end
            S_DDIVS: begin
                div_num_reg <= prod_reg;
                div_den_reg <= x1_reg - x0_reg;
                div_rem_reg <= 33'd0;
                div_ret_reg <= S_DNE;
            end
            S_DIV: begin
                div_rem_reg <= div_ge ? div_sh - {1'b0, div_den_reg} : div_sh;
                div_num_reg <= {div_num_reg[62:0], div_ge};
            end
            S_DNE: begin
                ne_reg <= dd_neg_reg ? {1'b0, d0_reg} - div_num_reg[24:0]
                                     : {1'b0, d0_reg} + div_num_reg[24:0];
            end
            S_NE2: lo_reg <= prod_reg;
            S_NE3: begin
                m_reg       <= wide_sum[63:16];
                div_num_reg <= {2'b00, ay, 30'd0};
                div_den_reg <= root_reg;
                div_rem_reg <= 33'd0;
                div_ret_reg <= S_SINR;
            end
            S_SINR: begin
                sn_reg      <= div_num_reg[30:0];
                div_num_reg <= {2'b00, ax, 30'd0};
                div_rem_reg <= 33'd0;
                div_ret_reg <= S_COSR;
            end
            S_COSR: cs_reg <= div_num_reg[30:0];
            S_BXH:  lo_reg <= prod_reg;
            S_BXS:  bx_res_reg <= sat_out(out_mag, !(neg_b ^ y_reg[31]));
            S_BYH:  lo_reg <= prod_reg;
            S_BYS:  by_res_reg <= sat_out(out_mag, neg_b ^ x_reg[31]);
            default: begin
            end
        endcase
    end

    // Sequencer and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= 6'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_OUT) m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (q_valid && !q_item.is_load) state_reg <= S_SQX;
                S_SQX:  state_reg <= S_SQY;
                S_SQY:  state_reg <= S_SQS;
                S_SQS: begin
                    cnt_reg   <= 6'd31;
                    state_reg <= S_SQRT;
                end
                S_SQRT: begin
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0) state_reg <= (root_next == 32'd0) ? S_OUT : S_XI;
                end
                S_XI:   state_reg <= S_XIC;
                S_XIC:  state_reg <= S_HLO;
                S_HLO:  state_reg <= S_HHI;
                S_HHI:  state_reg <= S_HADD;
                S_HADD: state_reg <= (hstep_reg == 3'd5) ? S_FS : S_HLO;
                S_FS:   state_reg <= S_FSR;
                S_FSR:  state_reg <= (n_eff < NW'(2)) ? S_NE1 : S_DRD;
                S_DRD:  state_reg <= S_DCHK;
                S_DCHK: begin
                    if (j_reg != '0 && prev_pos_reg <= cell_p && cell_p < pos_rd_reg)
                        state_reg <= S_DMUL;
                    else if (j_reg == n_eff - NW'(1))
                        state_reg <= S_NE1;
                    else
                        state_reg <= S_DRD;
                end
                S_DMUL:  state_reg <= S_DDIVS;
                S_DDIVS: begin
                    cnt_reg   <= 6'd63;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0) state_reg <= div_ret_reg;
                end
                S_DNE: state_reg <= S_NE1;
                S_NE1: state_reg <= S_NE2;
                S_NE2: state_reg <= S_NE3;
                S_NE3: begin
                    cnt_reg   <= 6'd63;
                    state_reg <= S_DIV;
                end
                S_SINR: begin
                    cnt_reg   <= 6'd63;
                    state_reg <= S_DIV;
                end
                S_COSR: state_reg <= S_BXL;
                S_BXL:  state_reg <= S_BXH;
                S_BXH:  state_reg <= S_BXS;
                S_BXS:  state_reg <= S_BYL;
                S_BYL:  state_reg <= S_BYH;
                S_BYH:  state_reg <= S_BYS;
                S_BYS:  state_reg <= S_OUT;
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && (!m_valid_reg || m_ready)) begin
            bx_out_reg <= bx_res_reg;
            by_out_reg <= by_res_reg;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/plasma_lens_field_kick.sv =====
// Plasma lens field kick. An input beat is either a profile node load or a
// particle; a particle beat yields one result beat with the Bx and By
// increments, a load beat yields none.
// Channels: s_* input beats and m_* result beats with valid/ready, and a
// cfg_* write channel (index 0 radial_scale, 1 field_scale, 2 node_count)
// that is always ready; write it only while the block is idle.
// A two-entry queue sits in front of the sequencer, so up to two beats are
// taken while the sequencer is busy. A load beat is written to the table in
// the idle state. A particle's work is set by the 32-step square root, up to
// three 64-step divisions and the node scan, with all products on one shared
// 32x32 multiplier; the density lookup is skipped when fewer than two nodes
// are in use. The next beat starts when one finishes.
// A result is held in the output register while m_ready is low; the
// sequencer then waits with its next result, and the queue fills and drops
// s_ready. Reset empties the queue, clears m_valid and restores the
// configuration defaults; the profile table is not cleared and must be
// loaded before nodes are put in use.
// Depends on plfk_pkg, plfk_front and plfk_back.
`default_nettype none
module plasma_lens_field_kick import plfk_pkg::*; #(
    parameter int MAX_NODES = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic [3:0]  s_node_index,
    input  wire logic [31:0] s_node_pos,
    input  wire logic [23:0] s_node_density,
    input  wire logic [15:0] s_cell_position,
    input  wire logic [31:0] s_px,
    input  wire logic [31:0] s_py,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_bx_change,
    output logic [31:0]      m_by_change,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cfg_t  cfg_reg;
    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.radial_scale <= RADIAL_SCALE_RESET;
            cfg_reg.field_scale  <= 32'd0;
            cfg_reg.node_count   <= 5'd0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_RADIAL_SCALE: cfg_reg.radial_scale <= cfg_data;
                CFG_FIELD_SCALE:  cfg_reg.field_scale  <= cfg_data;
                CFG_NODE_COUNT:   cfg_reg.node_count   <= cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    plfk_front #(.MAX_NODES(MAX_NODES)) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_node_index    (s_node_index),
        .s_node_pos      (s_node_pos),
        .s_node_density  (s_node_density),
        .s_cell_position (s_cell_position),
        .s_px            (s_px),
        .s_py            (s_py),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop)
    );

    plfk_back #(.MAX_NODES(MAX_NODES)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_bx_change (m_bx_change),
        .m_by_change (m_by_change)
    );

endmodule
`default_nettype wire

// ===== rtl/plfk_checker.sv =====
// Port-level checks of the plasma lens field kick block, bound to the top.
// Depends only on the top level's ports.
`default_nettype none
module plfk_sva (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_bx_change,
    input wire logic [31:0] m_by_change,
    input wire logic        cfg_ready
);

    // A stalled result beat holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_bx_change) && $stable(m_by_change))
        else $error("result beat changed while stalled");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Configuration writes are never back-pressured out of reset.
    a_cfg_ready: assert property (@(posedge aclk) aresetn |-> cfg_ready)
        else $error("configuration port not ready");

endmodule

bind plasma_lens_field_kick plfk_sva u_plfk_sva (.*);
`default_nettype wire

// ===== dv/plfk_checker.sv =====
// Checker for the plasma lens field kick block: tracks configuration writes and
// profile loads, predicts each particle's Bx/By kick and compares result beats.
// Depends on plfk_pkg for register indexes, function codes and coefficients.
`timescale 1ns / 100ps
module plfk_checker import plfk_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_func,
    input  logic [3:0]  s_node_index,
    input  logic [31:0] s_node_pos,
    input  logic [23:0] s_node_density,
    input  logic [15:0] s_cell_position,
    input  logic [31:0] s_px,
    input  logic [31:0] s_py,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_bx_change,
    input  logic [31:0] m_by_change,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          errors,
    output int          pending
);

    typedef struct {
        logic [31:0] bx;
        logic [31:0] by;
    } kick_t;

    kick_t           kick_q[$];
    logic [31:0]     radial_q;
    logic [31:0]     field_q;
    logic [4:0]      nodes_in_use;
    logic [31:0]     node_pos_tbl[16];
    logic [23:0]     node_dens_tbl[16];

    function automatic longint unsigned mag(input longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint acc_clamp(input longint a);
        longint lim;
        lim = longint'(1) << 38;
        if (a > lim) return lim;
        if (a < -lim) return -lim;
        return a;
    endfunction

    // Product with xi in Q16.16, truncated toward zero.
    function automatic longint times_xi(input longint a, input longint unsigned xi);
        longint unsigned p;
        p = (mag(a) * xi) >> 16;
        return a < 0 ? -longint'(p) : longint'(p);
    endfunction

    // Linear interpolation over the first matching segment; 1.0 when none.
    function automatic longint unsigned density_at(input logic [15:0] cell_idx);
        int n;
        longint unsigned p, x0, x1, q;
        longint d0, dd, v;
        n = nodes_in_use > 16 ? 16 : nodes_in_use;
        p = longint'(cell_idx) << 16;
        if (n < 2) return 65536;
        for (int l = 0; l + 1 < n; l++) begin
            x0 = node_pos_tbl[l];
            x1 = node_pos_tbl[l + 1];
            if (p >= x0 && p < x1) begin
                d0 = node_dens_tbl[l];
                dd = longint'(node_dens_tbl[l + 1]) - d0;
                q = (mag(dd) * (p - x0)) / (x1 - x0);
                v = dd < 0 ? d0 - longint'(q) : d0 + longint'(q);
                return longint'(v[31:0]);
            end
        end
        return 65536;
    endfunction

    function automatic logic [31:0] kick_out(input longint unsigned m,
                                             input longint unsigned s, input bit neg);
        longint unsigned rr;
        rr = (((m >> 32) * s) << 2) + (((m & 64'hFFFF_FFFF) * s) >> 30);
        if (neg) begin
            if (rr > 64'h8000_0000) rr = 64'h8000_0000;
            return 32'(64'd0 - rr);
        end
        if (rr > 64'h7FFF_FFFF) rr = 64'h7FFF_FFFF;
        return rr[31:0];
    endfunction

    function automatic kick_t predict_kick(input logic [15:0] cell_idx,
                                           input logic [31:0] x32, input logic [31:0] y32);
        kick_t k;
        longint x, y, acc, fs;
        longint unsigned ax, ay, r, xi, m, sn, cs;
        bit neg_b;
        x = longint'($signed(x32));
        y = longint'($signed(y32));
        fs = longint'($signed(field_q));
        ax = mag(x);
        ay = mag(y);
        r = root64(ax * ax + ay * ay);
        k.bx = '0;
        k.by = '0;
        if (r == 0) return k;
        xi = (r * longint'(radial_q)) >> 24;
        if (xi > (longint'(1) << 24)) xi = longint'(1) << 24;
        acc = longint'(COEF_TOP);
        for (int i = 0; i < 5; i++)
            acc = acc_clamp(times_xi(acc, xi) + longint'(HORNER_COEF[i]));
        acc = acc_clamp(times_xi(acc, xi));
        m = ((mag(acc) >> 16) * mag(fs)) >> 16;
        m = (m * density_at(cell_idx)) >> 16;
        neg_b = (acc < 0) != (fs < 0);
        sn = (ay << 30) / r;
        cs = (ax << 30) / r;
        k.bx = kick_out(m, sn, !(neg_b != (y < 0)));
        k.by = kick_out(m, cs, neg_b != (x < 0));
        return k;
    endfunction

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        $display("%0t ERROR %s: expected %h got %h", $realtime, what, want, got);
        errors++;
    endtask

    always @(posedge aclk) begin : watch
        kick_t want;
        if (!aresetn) begin
            errors = 0;
            radial_q = RADIAL_SCALE_RESET;
            field_q = '0;
            nodes_in_use = '0;
            kick_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_RADIAL_SCALE: radial_q = cfg_data;
                    CFG_FIELD_SCALE:  field_q = cfg_data;
                    CFG_NODE_COUNT:   nodes_in_use = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_func == FUNC_LOAD) begin
                    node_pos_tbl[s_node_index] = s_node_pos;
                    node_dens_tbl[s_node_index] = s_node_density;
                end else begin
                    kick_q.push_back(predict_kick(s_cell_position, s_px, s_py));
                end
            end
            if (m_valid && m_ready) begin
                if (kick_q.size() == 0) begin
                    report("unexpected beat", '0, m_bx_change);
                end else begin
                    want = kick_q.pop_front();
                    if (m_bx_change !== want.bx) report("bx_change", want.bx, m_bx_change);
                    if (m_by_change !== want.by) report("by_change", want.by, m_by_change);
                end
            end
        end
        pending <= kick_q.size();
    end

endmodule

// ===== dv/tb.sv =====
// Top of the plasma lens field kick testbench: clock, reset, stimulus and verdict.
// Depends on plfk_pkg, the plasma_lens_field_kick RTL and dv/plfk_checker.sv.
`timescale 1ns / 100ps
module tb import plfk_pkg::*;;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_func;
    logic [3:0]  s_node_index;
    logic [31:0] s_node_pos;
    logic [23:0] s_node_density;
    logic [15:0] s_cell_position;
    logic [31:0] s_px;
    logic [31:0] s_py;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_bx_change;
    logic [31:0] m_by_change;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    int          errors;
    int          pending;
    bit          quiet;
    int          rx_hold;
    int          stuck;

    localparam int SETTLE = 400;
    localparam int STUCK_LIMIT = 20000;

    plasma_lens_field_kick i_dut (.*);
    plfk_checker i_checker (.*);

    always begin
        #6 aclk = 1'b0;
        #6 aclk = 1'b1;
    end

    // Result side: a random stall, possibly none, after every accepted beat, none in quiet phases.
    always @(posedge aclk) begin : rx
        int n;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold <= 0;
        end else if (m_valid && m_ready) begin
            n = quiet ? 0 : $urandom_range(0, 8);
            rx_hold <= n;
            m_ready <= (n == 0);
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= (rx_hold == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            stuck <= 0;
        end else begin
            stuck <= stuck + 1;
            if (stuck >= STUCK_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Leaves s_valid high after the beat; whoever pauses next lowers it.
    task automatic send_beat(input logic func, input logic [3:0] idx, input logic [31:0] pos,
                             input logic [23:0] dens, input logic [15:0] cell_idx,
                             input logic [31:0] x, input logic [31:0] y);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= func;
        s_node_index <= idx;
        s_node_pos <= pos;
        s_node_density <= dens;
        s_cell_position <= cell_idx;
        s_px <= x;
        s_py <= y;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic particle(input logic [15:0] cell_idx, input logic [31:0] x,
                            input logic [31:0] y);
        send_beat(FUNC_PARTICLE, 4'($urandom), $urandom, 24'($urandom), cell_idx, x, y);
    endtask

    task automatic load_node(input logic [3:0] idx, input logic [31:0] pos,
                             input logic [23:0] dens);
        send_beat(FUNC_LOAD, idx, pos, dens, 16'($urandom), $urandom, $urandom);
    endtask

    // Stop sending and let every outstanding result and any load still in flight finish.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Coordinates over the whole range of magnitudes, zero now and then.
    function automatic logic [31:0] rand_coord();
        int v;
        v = $urandom;
        if ($urandom_range(0, 15) == 0) return '0;
        return 32'(v >>> $urandom_range(0, 31));
    endfunction

    // Full table reload: mostly rising positions, sometimes random noise.
    task automatic load_profile(input bit scrambled);
        logic [31:0] pos;
        pos = $urandom_range(0, 100) << 16;
        for (int i = 0; i < 16; i++) begin
            if (scrambled) begin
                load_node(4'(i), $urandom, 24'($urandom));
            end else begin
                load_node(4'(i), pos, 24'($urandom_range(0, 24'h02_0000)));
                pos = pos + $urandom_range(0, 40 << 16);
            end
        end
    endtask

    initial begin
        logic [31:0] rs;
        logic [31:0] fs;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_func = FUNC_LOAD;
        s_node_index = '0;
        s_node_pos = '0;
        s_node_density = '0;
        s_cell_position = '0;
        s_px = '0;
        s_py = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_RADIAL_SCALE;
        cfg_data = '0;
        quiet = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: evenly spaced table with density extremes at the ends.
        for (int i = 0; i < 16; i++)
            load_node(4'(i), 32'((i * 16) << 16),
                      (i == 0) ? 24'h0 : (i == 15) ? 24'hFF_FFFF : 24'h1_0000);
        drain();
        set_reg(CFG_RADIAL_SCALE, RADIAL_SCALE_RESET);
        set_reg(CFG_FIELD_SCALE, 32'h0001_0000);
        set_reg(CFG_NODE_COUNT, 32'd16);
        particle(16'd0, 32'h0, 32'h0);
        particle(16'd5, 32'h7FFF_FFFF, 32'h0);
        particle(16'd17, 32'h0, 32'h8000_0000);
        particle(16'd239, 32'h8000_0000, 32'h8000_0000);
        particle(16'd40, 32'h0001_0000, 32'hFFFF_0000);
        particle(16'd300, 32'h0000_8000, 32'h0003_0000);
        particle(16'd65535, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        particle(16'd8, 32'hFFFF_FFFF, 32'h0000_0001);
        drain();
        set_reg(CFG_RADIAL_SCALE, 32'h0);
        set_reg(CFG_FIELD_SCALE, 32'h8000_0000);
        set_reg(CFG_NODE_COUNT, 32'd1);
        particle(16'd3, 32'h0002_0000, 32'h0001_0000);
        particle(16'd3, 32'hFFFE_0000, 32'h8000_0000);
        drain();
        set_reg(CFG_RADIAL_SCALE, 32'hFFFF_FFFF);
        set_reg(CFG_FIELD_SCALE, 32'h7FFF_FFFF);
        set_reg(CFG_NODE_COUNT, 32'd0);
        particle(16'd3, 32'h0000_0100, 32'hFFFF_FF00);
        particle(16'd9, 32'h8000_0000, 32'h7FFF_FFFF);

        // Random phases, each with its own settings and table.
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            quiet = (ph % 3 == 2);
            case ($urandom_range(0, 3))
                0: rs = $urandom;
                1: rs = 32'h0;
                2: rs = 32'hFFFF_FFFF;
                default: rs = $urandom_range(32'h0010_0000, 32'h0400_0000);
            endcase
            fs = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom_range(0, 1 << 18)))
                 * (($urandom_range(0, 1) == 1) ? -1 : 1);
            set_reg(CFG_RADIAL_SCALE, rs);
            set_reg(CFG_FIELD_SCALE, fs);
            set_reg(CFG_NODE_COUNT, (ph == 7) ? 32'd16 : 32'($urandom_range(0, 16)));
            load_profile($urandom_range(0, 4) == 0);
            for (int i = 0; i < 88; i++) begin
                if ($urandom_range(0, 19) == 0)
                    load_node(4'($urandom), $urandom, 24'($urandom));
                else if ($urandom_range(0, 7) == 0)
                    particle(16'($urandom), rand_coord(), rand_coord());
                else
                    particle(16'($urandom_range(0, 800)), rand_coord(), rand_coord());
            end
        end
        drain();

        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
